/* src/sca_pkg.sv */
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types, widths and constants of the size-class block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

   // Field and register widths
   localparam int MAX_CLASSES = 4;
   localparam int SIZE_W      = 13;
   localparam int CNT_W       = 9;
   localparam int SPAN_W      = SIZE_W + CNT_W;
   localparam int ADDR_W      = 32;
   localparam int REQ_W       = 16;
   localparam int EXTRA_W     = 16;
   localparam int STATUS_W    = 3;
   localparam int CLASS_W     = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int SETTLE_W    = $clog2(MAX_CLASSES + 1);

   // Parameter defaults
   localparam int DEF_NUM_CLASSES      = 4;
   localparam int DEF_BLOCKS_PER_CLASS = 256;
   localparam int DEF_POOL_BASE        = 4096;

   // Register map: size registers first, then count registers
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_COUNT = 3'd4;

   localparam logic [CNT_W-1:0] COUNT_RESET = 9'd256;

   // Request modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_POOL_ALLOC = 3'd0,
      STAT_FALLBACK   = 3'd1,
      STAT_BAD_SIZE   = 3'd2,
      STAT_POOL_FREE  = 3'd3,
      STAT_EXTRA_FREE = 3'd4,
      STAT_NULL       = 3'd5,
      STAT_ERROR      = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_LOOKUP = 2'd1,
      S_RESULT = 2'd2
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic lookup;
      logic load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic cfg_busy;
   } dp_stat_type;

   // Block size of class c after reset: 64, 128, 256, 512
   function automatic logic [SIZE_W-1:0] size_reset(input int unsigned c);
      return SIZE_W'(64 << c);
   endfunction

endpackage

`default_nettype wire

/* src/size_class_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit
// Pool of fixed-size block classes with a LIFO free stack per class.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_* (valid/stall): mode 0 allocates request_size
//   bytes, mode 1 frees block_address. Each request gives one response on
//   rsp_* (valid/stall) with status, granted address, class and the count
//   of outstanding fallback blocks.
//   An accepted request passes the lookup state and then the result state
//   before rsp_valid rises. The lookup state looks up the classes and reads
//   or writes the single-port free-stack memory; the result state forms the
//   response and can take the next request. The response sits in an output
//   register; while the receiver stalls it holds, one more request may be
//   looked up, and req_stall stays high until the register frees.
//   The csr_* port writes block sizes (index 0..3) and block counts (index
//   4..7); a count write refills that class. Class bases ripple through one
//   class per cycle, so req_stall stays high during a write and until the
//   settle counter runs down. Reset (synchronous) restores the default
//   classes, clears the extra count and likewise holds requests off.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_block_allocator_unit #(
   parameter int NUM_CLASSES      = sca_pkg::DEF_NUM_CLASSES,
   parameter int BLOCKS_PER_CLASS = sca_pkg::DEF_BLOCKS_PER_CLASS,
   parameter int POOL_BASE        = sca_pkg::DEF_POOL_BASE
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [sca_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sca_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_mode,
   input  wire logic [sca_pkg::REQ_W-1:0]      req_request_size,
   input  wire logic [sca_pkg::ADDR_W-1:0]     req_block_address,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [sca_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [sca_pkg::ADDR_W-1:0]     rsp_granted_address,
   output logic      [sca_pkg::CLASS_W-1:0]    rsp_class_used,
   output logic      [sca_pkg::EXTRA_W-1:0]    rsp_extra_outstanding
);

   sca_pkg::cmd_type     cmd;
   sca_pkg::dp_stat_type stat;

   sca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sca_dp #(
      .NUM_CLASSES      (NUM_CLASSES),
      .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS),
      .POOL_BASE        (POOL_BASE)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_mode              (req_mode),
      .req_request_size      (req_request_size),
      .req_block_address     (req_block_address),
      .rsp_status            (rsp_status),
      .rsp_granted_address   (rsp_granted_address),
      .rsp_class_used        (rsp_class_used),
      .rsp_extra_outstanding (rsp_extra_outstanding)
   );

endmodule

`default_nettype wire

/* src/sca_ram.sv */
// ----------------------------------------------------------------------------
// sca_ram
// Single-port RAM with registered read data and a read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic             re,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* src/sca_ctrl.sv */
// ----------------------------------------------------------------------------
// sca_ctrl
// Request sequencer: accept, look up, then hand the result to the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire sca_pkg::dp_stat_type stat,
   output sca_pkg::cmd_type          cmd
);

   sca_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic can_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sca_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      can_accept = 1'b0;
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         sca_pkg::S_IDLE: begin
            can_accept = !stat.cfg_busy;
            if (req_valid && can_accept) begin
               state_in = sca_pkg::S_LOOKUP;
            end
         end
         sca_pkg::S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = sca_pkg::S_RESULT;
         end
         sca_pkg::S_RESULT: begin
            // take the next request in the same cycle the result leaves
            can_accept = out_free && !stat.cfg_busy;
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = (req_valid && can_accept) ? sca_pkg::S_LOOKUP
                                                        : sca_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sca_pkg::S_IDLE;
         end
      endcase
      cmd.accept   = req_valid && can_accept;
      rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   assign req_stall = !can_accept;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* src/sca_dp.sv */
// ----------------------------------------------------------------------------
// sca_dp
// Allocator datapath: class registers, region bases, free counts, the free
// stack memory, the extra-block counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_dp #(
   parameter int NUM_CLASSES      = sca_pkg::DEF_NUM_CLASSES,
   parameter int BLOCKS_PER_CLASS = sca_pkg::DEF_BLOCKS_PER_CLASS,
   parameter int POOL_BASE        = sca_pkg::DEF_POOL_BASE
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sca_pkg::cmd_type                   cmd,
   output sca_pkg::dp_stat_type                    stat,
   input  wire logic                               csr_write_en,
   input  wire logic [sca_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [sca_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                               req_mode,
   input  wire logic [sca_pkg::REQ_W-1:0]          req_request_size,
   input  wire logic [sca_pkg::ADDR_W-1:0]         req_block_address,
   output logic      [sca_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [sca_pkg::ADDR_W-1:0]         rsp_granted_address,
   output logic      [sca_pkg::CLASS_W-1:0]        rsp_class_used,
   output logic      [sca_pkg::EXTRA_W-1:0]        rsp_extra_outstanding
);

   localparam int MAXC    = sca_pkg::MAX_CLASSES;
   localparam int SIZE_W  = sca_pkg::SIZE_W;
   localparam int CNT_W   = sca_pkg::CNT_W;
   localparam int SPAN_W  = sca_pkg::SPAN_W;
   localparam int ADDR_W  = sca_pkg::ADDR_W;
   localparam int REQ_W   = sca_pkg::REQ_W;
   localparam int EXTRA_W = sca_pkg::EXTRA_W;
   localparam int CLASS_W = sca_pkg::CLASS_W;
   localparam int DEPTH   = NUM_CLASSES * BLOCKS_PER_CLASS;
   localparam int MEM_AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SLOT_W  = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
   localparam int EXT_W   = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;
   localparam int PROD_W  = SLOT_W + SIZE_W;
   localparam int CNT_MAX = (1 << CNT_W) - 1;
   localparam int CAP_INT = (BLOCKS_PER_CLASS > CNT_MAX) ? CNT_MAX : BLOCKS_PER_CLASS;
   localparam logic [CNT_W-1:0] CntCap = CNT_W'(CAP_INT);
   localparam logic [sca_pkg::SETTLE_W-1:0] SettleLen = sca_pkg::SETTLE_W'(NUM_CLASSES);

   // Blocks a class really holds: none for size 0, capped at the class depth
   function automatic logic [CNT_W-1:0] eff_count(input logic [SIZE_W-1:0] sz,
                                                  input logic [CNT_W-1:0]  ct);
      logic [CNT_W-1:0] r;
      if (sz == '0) begin
         r = '0;
      end else if (ct > CntCap) begin
         r = CntCap;
      end else begin
         r = ct;
      end
      return r;
   endfunction

   function automatic logic [SPAN_W-1:0] span_of(input logic [SIZE_W-1:0] sz,
                                                 input logic [CNT_W-1:0]  ct);
      return SPAN_W'(sz) * SPAN_W'(ct);
   endfunction

   function automatic logic [SLOT_W-1:0] to_slot(input logic [CNT_W-1:0] v);
      logic [EXT_W-1:0] t;
      t = EXT_W'(v);
      return t[SLOT_W-1:0];
   endfunction

   // Class registers and derived regions
   logic [SIZE_W-1:0]  size_ff  [MAXC];
   logic [CNT_W-1:0]   count_ff [MAXC];
   logic [SPAN_W-1:0]  span_ff  [MAXC];
   logic [ADDR_W-1:0]  base_ff  [MAXC];
   logic [CNT_W-1:0]   fc_ff    [MAXC];
   logic [CNT_W-1:0]   lwm_ff   [MAXC];
   logic [sca_pkg::SETTLE_W-1:0] settle_ff;

   // Configuration write decode
   logic [CLASS_W-1:0] csr_cls;
   logic               csr_is_count;
   logic [SIZE_W-1:0]  mul_size;
   logic [CNT_W-1:0]   mul_cnt;
   logic [SPAN_W-1:0]  new_span;

   always_comb begin
      csr_cls      = csr_index[CLASS_W-1:0];
      csr_is_count = (csr_index >= sca_pkg::CSR_FIRST_COUNT);
      mul_size     = csr_is_count ? size_ff[csr_cls] : csr_wdata[SIZE_W-1:0];
      mul_cnt      = eff_count(mul_size, csr_is_count ? csr_wdata[CNT_W-1:0]
                                                      : count_ff[csr_cls]);
      new_span     = span_of(mul_size, mul_cnt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAXC; c++) begin
            size_ff[c]  <= sca_pkg::size_reset(c);
            count_ff[c] <= sca_pkg::COUNT_RESET;
            span_ff[c]  <= span_of(sca_pkg::size_reset(c),
                                   eff_count(sca_pkg::size_reset(c), sca_pkg::COUNT_RESET));
         end
         settle_ff <= SettleLen;
      end else begin
         if (csr_write_en) begin
            if (csr_is_count) begin
               count_ff[csr_cls] <= csr_wdata[CNT_W-1:0];
            end else begin
               size_ff[csr_cls] <= csr_wdata[SIZE_W-1:0];
            end
            span_ff[csr_cls] <= new_span;
            settle_ff        <= SettleLen;
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - 1'b1;
         end
      end
   end

   // Prefix sums ripple one class per cycle; requests wait while they settle
   always_ff @(posedge clock) begin
      base_ff[0] <= ADDR_W'(POOL_BASE);
      for (int c = 1; c < MAXC; c++) begin
         base_ff[c] <= base_ff[c-1] + ADDR_W'(span_ff[c-1]);
      end
   end

   assign stat.cfg_busy = csr_write_en || (settle_ff != '0);

   // Request register
   logic              mode_ff;
   logic [REQ_W-1:0]  req_size_ff;
   logic [ADDR_W-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff     <= req_mode;
         req_size_ff <= req_request_size;
         addr_ff     <= req_block_address;
      end
   end

   // Per-class matching
   logic [ADDR_W-1:0] diff    [MAXC];
   logic [MAXC-1:0]   size_hit;
   logic [MAXC-1:0]   region_hit;

   always_comb begin
      for (int c = 0; c < MAXC; c++) begin
         diff[c]       = addr_ff - base_ff[c];
         region_hit[c] = (span_ff[c] != '0) && (addr_ff >= base_ff[c]) &&
                         (diff[c] < ADDR_W'(span_ff[c]));
         size_hit[c]   = (REQ_W'(size_ff[c]) == req_size_ff) && (fc_ff[c] != '0);
      end
   end

   // First matching class and its values
   logic [MAXC-1:0]    alloc_oh, free_oh, sel_oh;
   logic [CNT_W-1:0]   sel_fc, sel_lwm, sel_eff;
   logic [SIZE_W-1:0]  sel_size;
   logic [ADDR_W-1:0]  sel_base;
   logic [MEM_AW-1:0]  sel_off;
   logic [CLASS_W-1:0] sel_cls;

   always_comb begin
      alloc_oh = '0;
      free_oh  = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (size_hit[c] && (alloc_oh == '0)) begin
            alloc_oh[c] = 1'b1;
         end
         if (region_hit[c] && (free_oh == '0)) begin
            free_oh[c] = 1'b1;
         end
      end
      sel_oh   = (mode_ff == sca_pkg::MODE_ALLOC) ? alloc_oh : free_oh;
      sel_fc   = '0;
      sel_lwm  = '0;
      sel_eff  = '0;
      sel_size = '0;
      sel_base = '0;
      sel_off  = '0;
      sel_cls  = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (sel_oh[c]) begin
            sel_fc   = sel_fc | fc_ff[c];
            sel_lwm  = sel_lwm | lwm_ff[c];
            sel_eff  = sel_eff | eff_count(size_ff[c], count_ff[c]);
            sel_size = sel_size | size_ff[c];
            sel_base = sel_base | base_ff[c];
            sel_off  = sel_off | MEM_AW'(c * BLOCKS_PER_CLASS);
            sel_cls  = sel_cls | CLASS_W'(c);
         end
      end
   end

   // Decision
   logic               is_alloc, found, full, do_pop, do_push;
   logic [CNT_W-1:0]   fc_dec;
   logic [SLOT_W-1:0]  slot;
   logic [MEM_AW-1:0]  mem_addr;
   logic [PROD_W-1:0]  prod;
   sca_pkg::status_type status_in;
   logic [CLASS_W-1:0] cls_in;
   logic [EXTRA_W-1:0] extra_in;
   logic [EXTRA_W-1:0] extra_ff;

   always_comb begin
      is_alloc = (mode_ff == sca_pkg::MODE_ALLOC);
      found    = (sel_oh != '0);
      full     = (sel_fc >= sel_eff);
      do_pop   = is_alloc && (req_size_ff != '0) && found;
      do_push  = !is_alloc && (addr_ff != '0) && found && !full;
      fc_dec   = sel_fc - 1'b1;
      slot     = is_alloc ? to_slot(fc_dec) : to_slot(sel_fc);
      mem_addr = sel_off + MEM_AW'(slot);
      prod     = PROD_W'(slot) * PROD_W'(sel_size);

      status_in = sca_pkg::STAT_ERROR;
      cls_in    = '0;
      extra_in  = extra_ff;
      priority if (is_alloc && (req_size_ff == '0)) begin
         status_in = sca_pkg::STAT_BAD_SIZE;
      end else if (is_alloc && found) begin
         status_in = sca_pkg::STAT_POOL_ALLOC;
         cls_in    = sel_cls;
      end else if (is_alloc) begin
         status_in = sca_pkg::STAT_FALLBACK;
         if (extra_ff != '1) begin
            extra_in = extra_ff + 1'b1;
         end
      end else if (addr_ff == '0) begin
         status_in = sca_pkg::STAT_NULL;
      end else if (found) begin
         cls_in    = sel_cls;
         status_in = full ? sca_pkg::STAT_ERROR : sca_pkg::STAT_POOL_FREE;
      end else if (extra_ff == '0) begin
         status_in = sca_pkg::STAT_ERROR;
      end else begin
         status_in = sca_pkg::STAT_EXTRA_FREE;
         extra_in  = extra_ff - 1'b1;
      end
   end

   // Free counts and low-water marks. A slot at or above the low-water mark
   // has been pushed since the last refill and holds a stored address.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAXC; c++) begin
            fc_ff[c]  <= eff_count(sca_pkg::size_reset(c), sca_pkg::COUNT_RESET);
            lwm_ff[c] <= eff_count(sca_pkg::size_reset(c), sca_pkg::COUNT_RESET);
         end
         extra_ff <= '0;
      end else if (csr_write_en) begin
         if (csr_is_count) begin
            fc_ff[csr_cls]  <= mul_cnt;
            lwm_ff[csr_cls] <= mul_cnt;
         end
      end else if (cmd.lookup) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            if (sel_oh[c] && do_pop) begin
               fc_ff[c] <= fc_dec;
               if (fc_dec < lwm_ff[c]) begin
                  lwm_ff[c] <= fc_dec;
               end
            end else if (sel_oh[c] && do_push) begin
               fc_ff[c] <= sel_fc + 1'b1;
            end
         end
         extra_ff <= extra_in;
      end
   end

   // Lookup stage results
   sca_pkg::status_type status_ff;
   logic [CLASS_W-1:0]  cls_ff;
   logic                stored_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [ADDR_W-1:0]   base_sel_ff;
   logic [ADDR_W-1:0]   rd_data;

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         status_ff   <= status_in;
         cls_ff      <= cls_in;
         stored_ff   <= (sel_fc > sel_lwm);
         prod_ff     <= prod;
         base_sel_ff <= sel_base;
      end
   end

   sca_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (cmd.lookup && do_push),
      .re    (cmd.lookup && do_pop),
      .addr  (mem_addr),
      .wdata (addr_ff),
      .rdata (rd_data)
   );

   // Output register
   logic [sca_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]            rsp_granted_ff;
   logic [CLASS_W-1:0]           rsp_cls_ff;
   logic [EXTRA_W-1:0]           rsp_extra_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status_ff <= status_ff;
         rsp_cls_ff    <= cls_ff;
         rsp_extra_ff  <= extra_ff;
         if (status_ff == sca_pkg::STAT_POOL_ALLOC) begin
            rsp_granted_ff <= stored_ff ? rd_data : (base_sel_ff + ADDR_W'(prod_ff));
         end else begin
            rsp_granted_ff <= '0;
         end
      end
   end

   assign rsp_status            = rsp_status_ff;
   assign rsp_granted_address   = rsp_granted_ff;
   assign rsp_class_used        = rsp_cls_ff;
   assign rsp_extra_outstanding = rsp_extra_ff;

endmodule

`default_nettype wire

/* src/sca_checker.sv */
// ----------------------------------------------------------------------------
// sca_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [sca_pkg::STATUS_W-1:0]   rsp_status,
   input wire logic [sca_pkg::ADDR_W-1:0]     rsp_granted_address,
   input wire logic [sca_pkg::CLASS_W-1:0]    rsp_class_used,
   input wire logic [sca_pkg::EXTRA_W-1:0]    rsp_extra_outstanding
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_granted_address) && $stable(rsp_class_used) &&
      $stable(rsp_extra_outstanding))
      else $error("stalled response changed");

   // Only a pool allocation grants an address
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != sca_pkg::STAT_POOL_ALLOC) |->
      rsp_granted_address == '0)
      else $error("address granted without a pool allocation");

   // Responses that involve no class report class 0
   a_no_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == sca_pkg::STAT_BAD_SIZE) ||
                    (rsp_status == sca_pkg::STAT_NULL) ||
                    (rsp_status == sca_pkg::STAT_FALLBACK) ||
                    (rsp_status == sca_pkg::STAT_EXTRA_FREE)) |->
      rsp_class_used == '0)
      else $error("class reported on a response without a class");

   // A fallback always leaves at least one extra block outstanding
   a_fallback_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sca_pkg::STAT_FALLBACK) |->
      rsp_extra_outstanding != '0)
      else $error("fallback with no outstanding extra block");

   // The lookup cycle after an accepted request takes no new request
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted during lookup");

endmodule

bind size_class_block_allocator_unit sca_checker u_sca_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_valid),
   .req_stall             (req_stall),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_status            (rsp_status),
   .rsp_granted_address   (rsp_granted_address),
   .rsp_class_used        (rsp_class_used),
   .rsp_extra_outstanding (rsp_extra_outstanding)
);

`default_nettype wire
